// ===== design/luhn_pkg.sv =====
// Shared constants and the divide-by-ten step for the Luhn card classifier.
`default_nettype none
package luhn_pkg;

  localparam int unsigned CardW  = 64;
  localparam int unsigned ClassW = 2;
  localparam int unsigned CountW = 5;
  localparam int unsigned LeadW  = 7;
  localparam int unsigned RemW   = 4;
  localparam int unsigned ChunkW = 16;
  localparam int unsigned StepW  = 2;
  localparam int unsigned PartW  = RemW + ChunkW;
  localparam int unsigned RecipShift = 23;
  localparam int unsigned ProdW  = RecipShift + ChunkW;

  typedef logic [ClassW-1:0] card_class_t;

  localparam card_class_t CLASS_INVALID    = 2'd0;
  localparam card_class_t CLASS_AMEX       = 2'd1;
  localparam card_class_t CLASS_MASTERCARD = 2'd2;
  localparam card_class_t CLASS_VISA       = 2'd3;

  localparam logic [LeadW-1:0]  LEAD_AMEX_A = 7'd34;
  localparam logic [LeadW-1:0]  LEAD_AMEX_B = 7'd37;
  localparam logic [LeadW-1:0]  LEAD_MC_LO  = 7'd51;
  localparam logic [LeadW-1:0]  LEAD_MC_HI  = 7'd55;
  localparam logic [LeadW-1:0]  LEAD_VISA_LO = 7'd39;
  localparam logic [LeadW-1:0]  LEAD_VISA_HI = 7'd50;
  localparam logic [CountW-1:0] DIGITS_AMEX  = 5'd15;
  localparam logic [CountW-1:0] DIGITS_SHORT = 5'd13;
  localparam logic [CountW-1:0] DIGITS_LONG  = 5'd16;
  localparam logic [CountW-1:0] DIGITS_MAX   = 5'd20;
  localparam logic [CardW-1:0]  PAIR_LIMIT   = 64'd100;
  localparam logic [RemW-1:0]   TEN          = 4'd10;
  localparam logic [StepW-1:0]  LAST_STEP    = 2'd3;
  localparam logic [PartW-1:0]  DIV10_RECIP  = 20'd838861;

  typedef struct packed {
    logic [ChunkW-1:0] quot;
    logic [RemW-1:0]   rem;
  } div10_t;

  // One long-division step by ten on a 16-bit chunk; partial dividend stays below 655360.
  function automatic div10_t div10(input logic [RemW-1:0] r, input logic [ChunkW-1:0] v);
    logic [PartW-1:0] x;
    logic [ProdW-1:0] p;
    logic [PartW-1:0] qt;
    div10_t           res;
    x        = {r, v};
    p        = ProdW'(x) * ProdW'(DIV10_RECIP);
    res.quot = p[RecipShift +: ChunkW];
    qt       = PartW'(res.quot) * PartW'(TEN);
    res.rem  = RemW'(x - qt);
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/card_number_luhn_classifier_top.sv =====
// Luhn mod-10 card number checker and classifier, top level.
// A card number is taken when in_valid_i and in_ready_o are high. The block then
// peels one decimal digit at a time through a shared divide-by-ten unit that
// handles 16 bits of the value per cycle, keeping the digit count, the Luhn sum modulo
// ten and the two leading digits, and then classifies the number into an output
// register. A number has at most 20 decimal digits. in_ready_o stays low from the
// accept until the result is registered, and longer while a finished result waits
// for a full output register to drain. A finished result may wait in the output
// register while the next number is accepted.
`default_nettype none
module card_number_luhn_classifier_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [luhn_pkg::CardW-1:0]  card_number_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [luhn_pkg::ClassW-1:0]      card_class_o,
  output logic                             luhn_ok_o,
  output logic [luhn_pkg::CountW-1:0]      digit_count_o,
  output logic [luhn_pkg::LeadW-1:0]       leading_two_o
);
  import luhn_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_q, state_d;
  logic [CardW-1:0]  val_q, val_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [CountW-1:0] digits_q, digits_d;
  logic [RemW-1:0]   sum_q, sum_d;
  logic [LeadW-1:0]  lead_q, lead_d;
  logic              lead_done_q, lead_done_d;
  logic              out_valid_q, out_valid_d;
  card_class_t       class_q, class_d;
  logic              ok_q, ok_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [LeadW-1:0]  lead_out_q, lead_out_d;

  div10_t            div;
  logic [RemW-1:0]   dig_term;
  logic [RemW:0]     sum_add;
  logic [LeadW-1:0]  lead_now;
  logic              below_pair;
  logic              val_zero;
  logic              finish;
  logic              accept;
  card_class_t       cls;
  logic              ok;

  assign div        = div10(rem_q, val_q[CardW-1 -: ChunkW]);
  assign below_pair = (val_q < PAIR_LIMIT);
  assign val_zero   = (val_q == '0);
  assign lead_now   = lead_done_q ? lead_q : val_q[LeadW-1:0];
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = (state_q == ST_RUN) && (step_q == '0) && val_zero &&
                      (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    if (!digits_q[0]) begin
      dig_term = div.rem;
    end else if (div.rem < 4'd5) begin
      dig_term = 4'(div.rem << 1);
    end else begin
      dig_term = 4'((5'(div.rem) << 1) - 5'd9);
    end
    sum_add = 5'(sum_q) + 5'(dig_term);
  end

  always_comb begin
    ok  = (sum_q == '0);
    cls = CLASS_INVALID;
    if (ok) begin
      if (digits_q == DIGITS_AMEX && (lead_now == LEAD_AMEX_A || lead_now == LEAD_AMEX_B)) begin
        cls = CLASS_AMEX;
      end else if (digits_q == DIGITS_SHORT || digits_q == DIGITS_LONG) begin
        if (lead_now >= LEAD_MC_LO && lead_now <= LEAD_MC_HI) begin
          cls = CLASS_MASTERCARD;
        end else if (lead_now > LEAD_VISA_LO && lead_now < LEAD_VISA_HI) begin
          cls = CLASS_VISA;
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    step_d      = step_q;
    rem_d       = rem_q;
    digits_d    = digits_q;
    sum_d       = sum_q;
    lead_d      = lead_q;
    lead_done_d = lead_done_q;
    out_valid_d = out_valid_q;
    class_d     = class_q;
    ok_d        = ok_q;
    cnt_d       = cnt_q;
    lead_out_d  = lead_out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d     = ST_RUN;
          val_d       = card_number_i;
          step_d      = '0;
          rem_d       = '0;
          digits_d    = '0;
          sum_d       = '0;
          lead_done_d = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_q == '0 && below_pair && !lead_done_q) begin
          lead_d      = val_q[LeadW-1:0];
          lead_done_d = 1'b1;
        end
        if (step_q != '0 || !val_zero) begin
          val_d  = {val_q[CardW-ChunkW-1:0], div.quot};
          step_d = step_q + 1'b1;
          rem_d  = div.rem;
          if (step_q == LAST_STEP) begin
            rem_d    = '0;
            digits_d = digits_q + 1'b1;
            sum_d    = (sum_add >= 5'(TEN)) ? 4'(sum_add - 5'(TEN)) : sum_add[RemW-1:0];
          end
        end else if (finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          class_d     = cls;
          ok_d        = ok;
          cnt_d       = digits_q;
          lead_out_d  = lead_now;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lead_done_q <= 1'b0;
      step_q      <= '0;
      rem_q       <= '0;
      digits_q    <= '0;
      sum_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lead_done_q <= lead_done_d;
      step_q      <= step_d;
      rem_q       <= rem_d;
      digits_q    <= digits_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    lead_q     <= lead_d;
    class_q    <= class_d;
    ok_q       <= ok_d;
    cnt_q      <= cnt_d;
    lead_out_q <= lead_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign card_class_o  = class_q;
  assign luhn_ok_o     = ok_q;
  assign digit_count_o = cnt_q;
  assign leading_two_o = lead_out_q;

  a_digits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q <= DIGITS_MAX)
    else $error("digit count out of range");

  a_sum_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q < TEN)
    else $error("running Luhn sum not reduced");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (digits_q == '0) && (sum_q == '0) &&
               (step_q == '0) && !lead_done_q)
    else $error("sequencer did not start clean");

  a_class_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !ok_q |-> class_q == CLASS_INVALID)
    else $error("class given without Luhn pass");

endmodule
`default_nettype wire
